// File: rtl/rtue_pkg.sv
// Shared types and constants for the route table update engine.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package rtue_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam int DEST_W   = 32;
    localparam int HOP_W    = 32;
    localparam int COST_W   = 16;
    localparam int IFACE_W  = 4;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 6;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADDED     = 3'd0,
        STAT_EXISTED   = 3'd1,
        STAT_UPDATED   = 3'd2,
        STAT_WITHDREW  = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_FULL      = 3'd5
    } status_t;

    typedef enum logic {
        KIND_ADD      = 1'b0,
        KIND_WITHDRAW = 1'b1
    } kind_t;

    typedef struct packed {
        logic [DEST_W-1:0]  dest;
        logic [HOP_W-1:0]   hop;
        logic [COST_W-1:0]  cost;
        logic [IFACE_W-1:0] iface;
    } route_t;

    typedef struct packed {
        logic   valid;
        route_t route;
    } slot_t;

    // Search results rippling along the row of cells, newest slot first.
    typedef struct packed {
        logic dec_found;
        logic wd_found;
        logic hit_ident;
    } chain_t;

    // Broadcast control for the update cycle.
    typedef struct packed {
        logic  apply;
        kind_t kind;
        logic  add_found;
        logic  add_full;
        logic  wd_found;
    } ctl_t;

endpackage

`default_nettype wire

// File: rtl/rtue_cell.sv
// One route slot of the table: stored route, match flags and update logic.
// Depends on rtue_pkg; instantiated once per slot by route_table_update_engine.
`default_nettype none

module rtue_cell
    import rtue_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cap,
    input  wire logic [DEST_W-1:0]  cmp_dest,
    input  wire logic [HOP_W-1:0]   cmp_hop,
    input  wire logic [COST_W-1:0]  cmp_cost,
    input  wire logic [IFACE_W-1:0] cmp_iface,
    input  wire route_t             item,
    input  wire slot_t              prev_slot,
    input  wire slot_t              next_slot,
    input  wire chain_t             chain_in,
    input  wire ctl_t               ctl,
    output slot_t                   slot_out,
    output chain_t                  chain_out
);

    logic   valid_reg;
    logic   valid_next;
    route_t route_reg;
    route_t route_next;
    logic   dec_flag_reg;
    logic   ident_flag_reg;
    logic   wd_flag_reg;
    logic   same_key;
    logic   ident;
    logic   dec;
    logic   wd;
    logic   hit_dec;

    assign same_key = (route_reg.dest == cmp_dest) && (route_reg.iface == cmp_iface);
    assign ident    = same_key && (route_reg.hop == cmp_hop) && (route_reg.cost == cmp_cost);
    assign dec      = valid_reg && (ident || (same_key && (cmp_cost < route_reg.cost)));
    assign wd       = valid_reg && (route_reg.dest == cmp_dest);

    // The first cell with a flag set, seen from the newest slot, owns the hit.
    assign hit_dec             = dec_flag_reg && !chain_in.dec_found;
    assign chain_out.dec_found = chain_in.dec_found | dec_flag_reg;
    assign chain_out.wd_found  = chain_in.wd_found | wd_flag_reg;
    assign chain_out.hit_ident = chain_in.hit_ident | (hit_dec & ident_flag_reg);

    assign slot_out.valid = valid_reg;
    assign slot_out.route = route_reg;

    always_comb
    begin
        valid_next = valid_reg;
        route_next = route_reg;
        if (ctl.apply)
        begin
            if (ctl.kind == KIND_ADD)
            begin
                if (ctl.add_found)
                begin
                    if (hit_dec && !ident_flag_reg)
                    begin
                        route_next = item;
                    end
                end
                else if (!ctl.add_full)
                begin
                    valid_next = prev_slot.valid;
                    route_next = prev_slot.route;
                end
            end
            else if (ctl.wd_found && (chain_in.wd_found || wd_flag_reg))
            begin
                // The withdrawn slot and all older ones close the gap.
                valid_next = next_slot.valid;
                route_next = next_slot.route;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        route_reg <= route_next;
        if (cap)
        begin
            dec_flag_reg   <= dec;
            ident_flag_reg <= ident;
            wd_flag_reg    <= wd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/route_table_update_engine.sv
// Route table update engine: a row of slot cells, control and result register.
// Depends on rtue_pkg and rtue_cell.
//
// Usage: each input request (kind, dst_ip, next_hop, cost, iface) is taken on
// in_valid & in_ready and produces exactly one result (status, entries_used)
// on the out_valid / out_ready channel. The table is a row of TABLE_DEPTH
// cells, newest route in cell 0; every cell compares against the request in
// the cycle it is accepted, and once the result register is free the first
// hit found along the row decides the update, with routes shifting one cell
// back on an insert or one cell forward on a withdraw.
// The result is registered when the update is applied. A new request is
// accepted only after the previous update is applied; in_ready is low while
// the update is pending.
// A pending result does not block acceptance of the next request, but if the
// receiver still stalls when the following update is ready, the update waits
// until out_ready frees the result register.
// Reset clears every valid bit and the route count; the table starts empty
// and no clearing pass is needed.
`default_nettype none

module route_table_update_engine
    import rtue_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                kind,
    input  wire logic [DEST_W-1:0]   dst_ip,
    input  wire logic [HOP_W-1:0]    next_hop,
    input  wire logic [COST_W-1:0]   cost,
    input  wire logic [IFACE_W-1:0]  iface,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [USED_W-1:0]        entries_used
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'b01,
        FSM_APPLY = 2'b10
    } fsm_t;

    fsm_t                 state_reg;
    fsm_t                 state_next;
    route_t               item_reg;
    kind_t                kind_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    status_t              status_reg;
    status_t              status_next;
    logic [USED_W-1:0]    used_reg;
    logic                 cap;
    logic                 apply_fire;
    ctl_t                 ctl;
    chain_t               chain_w [TABLE_DEPTH+1];
    slot_t                slot_w [TABLE_DEPTH];
    slot_t                head_slot;
    logic [TABLE_DEPTH-1:0] valid_vec;

    assign in_ready   = (state_reg == FSM_IDLE);
    assign cap        = in_valid && in_ready;
    assign apply_fire = (state_reg == FSM_APPLY) && (!out_valid_reg || out_ready);

    assign head_slot.valid = 1'b1;
    assign head_slot.route = item_reg;

    assign chain_w[0] = '0;

    assign ctl.apply     = apply_fire;
    assign ctl.kind      = kind_reg;
    assign ctl.add_found = chain_w[TABLE_DEPTH].dec_found;
    assign ctl.add_full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign ctl.wd_found  = chain_w[TABLE_DEPTH].wd_found;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        slot_t prev_s;
        slot_t next_s;

        if (i == 0)
        begin : g_head
            assign prev_s = head_slot;
        end
        else
        begin : g_body
            assign prev_s = slot_w[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign next_s = '0;
        end
        else
        begin : g_mid
            assign next_s = slot_w[i+1];
        end

        rtue_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cap       (cap),
            .cmp_dest  (dst_ip),
            .cmp_hop   (next_hop),
            .cmp_cost  (cost),
            .cmp_iface (iface),
            .item      (item_reg),
            .prev_slot (prev_s),
            .next_slot (next_s),
            .chain_in  (chain_w[i]),
            .ctl       (ctl),
            .slot_out  (slot_w[i]),
            .chain_out (chain_w[i+1])
        );

        assign valid_vec[i] = slot_w[i].valid;
    end

    always_comb
    begin
        count_next = count_reg;
        if (kind_reg == KIND_WITHDRAW)
        begin
            if (ctl.wd_found)
            begin
                status_next = STAT_WITHDREW;
                count_next  = count_reg - CNT_W'(1);
            end
            else
            begin
                status_next = STAT_NOT_FOUND;
            end
        end
        else if (ctl.add_found)
        begin
            status_next = chain_w[TABLE_DEPTH].hit_ident ? STAT_EXISTED : STAT_UPDATED;
        end
        else if (ctl.add_full)
        begin
            status_next = STAT_FULL;
        end
        else
        begin
            status_next = STAT_ADDED;
            count_next  = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (cap)
                begin
                    state_next = FSM_APPLY;
                end
            end
            FSM_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            kind_reg       <= kind_t'(kind);
            item_reg.dest  <= dst_ip;
            item_reg.hop   <= next_hop;
            item_reg.cost  <= cost;
            item_reg.iface <= iface;
        end
        if (apply_fire)
        begin
            status_reg <= status_next;
            used_reg   <= USED_W'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entries_used = used_reg;

    // Valid slots always form a solid block from the newest cell.
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == count_reg)
        else $error("route count differs from number of valid slots");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        slot_w[0].valid == (count_reg != '0))
        else $error("newest slot validity disagrees with route count");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_fire && status_next == STAT_FULL) |-> ctl.add_full)
        else $error("full rejection issued with free slots");

    a_apply_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        apply_fire |=> (out_valid_reg && state_reg == FSM_IDLE))
        else $error("update cycle did not produce a result");

endmodule

`default_nettype wire
